@@ rtl/core/lfpd_pkg.sv @@
// Shared types, register map, constants and saturation helper for the
// line-following PID drive block. No dependencies.
`default_nettype none

package lfpd_pkg;

	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned SPEED_W  = 7;
	localparam int unsigned TGT_W    = 10;
	localparam int unsigned ERR_W    = 12;
	localparam int unsigned DEG_W    = 32;
	localparam int unsigned POWER_W  = 8;
	localparam int unsigned ISUM_W   = 8;
	localparam int unsigned PADDR_W  = 5;
	localparam int unsigned PDATA_W  = 32;

	// Q6.10 gains: correction is scaled down by 2^10
	localparam int unsigned GAIN_FRAC = 10;

	// distance check: (left - right) * 201 < target_cm * 7200
	localparam int unsigned ODO_DEG_MUL = 201;
	localparam int unsigned ODO_CM_MUL  = 7200;

	localparam logic [GAIN_W-1:0]  RST_STRAIGHT_KP    = 16'd5120;
	localparam logic [GAIN_W-1:0]  RST_STRAIGHT_KI    = 16'd10;
	localparam logic [GAIN_W-1:0]  RST_STRAIGHT_KD    = 16'd4096;
	localparam logic [GAIN_W-1:0]  RST_CURVE_KP       = 16'd10240;
	localparam logic [GAIN_W-1:0]  RST_CURVE_KI       = 16'd10;
	localparam logic [GAIN_W-1:0]  RST_CURVE_KD       = 16'd6144;
	localparam logic [SPEED_W-1:0] RST_STRAIGHT_SPEED = 7'd70;
	localparam logic [SPEED_W-1:0] RST_CURVE_SPEED    = 7'd40;

	typedef enum logic [2:0] {
		REG_STRAIGHT_KP    = 3'd0,
		REG_STRAIGHT_KI    = 3'd1,
		REG_STRAIGHT_KD    = 3'd2,
		REG_CURVE_KP       = 3'd3,
		REG_CURVE_KI       = 3'd4,
		REG_CURVE_KD       = 3'd5,
		REG_STRAIGHT_SPEED = 3'd6,
		REG_CURVE_SPEED    = 3'd7
	} reg_idx_t;

	typedef enum logic {
		CMD_START  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_IDLE    = 2'd0,
		STATUS_RUN     = 2'd1,
		STATUS_REACHED = 2'd2,
		STATUS_ABORTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  straight_kp;
		logic [GAIN_W-1:0]  straight_ki;
		logic [GAIN_W-1:0]  straight_kd;
		logic [GAIN_W-1:0]  curve_kp;
		logic [GAIN_W-1:0]  curve_ki;
		logic [GAIN_W-1:0]  curve_kd;
		logic [SPEED_W-1:0] straight_speed;
		logic [SPEED_W-1:0] curve_speed;
	} cfg_t;

	typedef struct packed {
		cmd_t                     command;
		logic                     curve_mode;
		logic [TGT_W-1:0]         target_distance_cm;
		logic signed [ERR_W-1:0]  line_error;
		logic signed [DEG_W-1:0]  left_degrees;
		logic signed [DEG_W-1:0]  right_degrees;
		logic                     abort_button;
	} item_t;

	typedef struct packed {
		logic signed [POWER_W-1:0] left_power;
		logic signed [POWER_W-1:0] right_power;
		logic                      brake;
		logic                      reset_counters;
		status_t                   status;
	} result_t;

	typedef struct packed {
		logic signed [ISUM_W-1:0]  integral_sum;
		logic signed [ERR_W-1:0]   previous_error;
		logic                      run_active;
		logic                      mode_curve;
		logic [TGT_W-1:0]          target_cm;
		logic signed [POWER_W-1:0] held_left_power;
		logic signed [POWER_W-1:0] held_right_power;
		logic                      brake_on;
	} state_t;

	// saturate to +-100
	function automatic logic signed [7:0] clamp100(input logic signed [23:0] v);
		logic signed [7:0] r;
		if (v > 24'sd100) begin
			r = 8'sd100;
		end else if (v < -24'sd100) begin
			r = -8'sd100;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lfpd_if.sv @@
// Valid/ready channel interfaces for the drive block: request items in,
// result items out. Depends on lfpd_pkg.
`default_nettype none

interface lfpd_req_if import lfpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic                    curve_mode;
	logic [TGT_W-1:0]        target_distance_cm;
	logic signed [ERR_W-1:0] line_error;
	logic signed [DEG_W-1:0] left_degrees;
	logic signed [DEG_W-1:0] right_degrees;
	logic                    abort_button;

	modport source (
		output valid, command, curve_mode, target_distance_cm, line_error,
			left_degrees, right_degrees, abort_button,
		input  ready
	);
	modport sink (
		input  valid, command, curve_mode, target_distance_cm, line_error,
			left_degrees, right_degrees, abort_button,
		output ready
	);
endinterface

interface lfpd_rsp_if import lfpd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POWER_W-1:0] left_power;
	logic signed [POWER_W-1:0] right_power;
	logic                      brake;
	logic                      reset_counters;
	logic [1:0]                status;

	modport source (
		output valid, left_power, right_power, brake, reset_counters, status,
		input  ready
	);
	modport sink (
		input  valid, left_power, right_power, brake, reset_counters, status,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/lfpd_cfg_regs.sv @@
// APB-style register file holding the PID gains and base speeds.
// Depends on lfpd_pkg.
`default_nettype none

module lfpd_cfg_regs import lfpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.straight_kp    <= RST_STRAIGHT_KP;
			cfg_q.straight_ki    <= RST_STRAIGHT_KI;
			cfg_q.straight_kd    <= RST_STRAIGHT_KD;
			cfg_q.curve_kp       <= RST_CURVE_KP;
			cfg_q.curve_ki       <= RST_CURVE_KI;
			cfg_q.curve_kd       <= RST_CURVE_KD;
			cfg_q.straight_speed <= RST_STRAIGHT_SPEED;
			cfg_q.curve_speed    <= RST_CURVE_SPEED;
		end else if (wr_en) begin
			unique case (idx)
				REG_STRAIGHT_KP:    cfg_q.straight_kp    <= pwdata[GAIN_W-1:0];
				REG_STRAIGHT_KI:    cfg_q.straight_ki    <= pwdata[GAIN_W-1:0];
				REG_STRAIGHT_KD:    cfg_q.straight_kd    <= pwdata[GAIN_W-1:0];
				REG_CURVE_KP:       cfg_q.curve_kp       <= pwdata[GAIN_W-1:0];
				REG_CURVE_KI:       cfg_q.curve_ki       <= pwdata[GAIN_W-1:0];
				REG_CURVE_KD:       cfg_q.curve_kd       <= pwdata[GAIN_W-1:0];
				REG_STRAIGHT_SPEED: cfg_q.straight_speed <= pwdata[SPEED_W-1:0];
				REG_CURVE_SPEED:    cfg_q.curve_speed    <= pwdata[SPEED_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STRAIGHT_KP:    prdata = {16'd0, cfg_q.straight_kp};
			REG_STRAIGHT_KI:    prdata = {16'd0, cfg_q.straight_ki};
			REG_STRAIGHT_KD:    prdata = {16'd0, cfg_q.straight_kd};
			REG_CURVE_KP:       prdata = {16'd0, cfg_q.curve_kp};
			REG_CURVE_KI:       prdata = {16'd0, cfg_q.curve_ki};
			REG_CURVE_KD:       prdata = {16'd0, cfg_q.curve_kd};
			REG_STRAIGHT_SPEED: prdata = {25'd0, cfg_q.straight_speed};
			REG_CURVE_SPEED:    prdata = {25'd0, cfg_q.curve_speed};
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/lfpd_step.sv @@
// Combinational update for one transaction: odometry check, abort, PID step
// and motor power saturation. Depends on lfpd_pkg.
`default_nettype none

module lfpd_step import lfpd_pkg::*; (
	input  item_t   item,
	input  state_t  cur,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t result
);

	logic signed [32:0] diff;
	logic signed [40:0] travel;
	logic               reached;

	logic [GAIN_W-1:0]  kp, ki, kd;
	logic [SPEED_W-1:0] spd;

	logic signed [12:0] isum_raw;
	logic signed [7:0]  isum;
	logic signed [12:0] d_err;
	logic signed [28:0] p_term;
	logic signed [24:0] i_term;
	logic signed [29:0] d_term;
	logic signed [31:0] pid_sum;
	logic signed [31:0] pid_round;
	logic signed [21:0] corr;
	logic signed [23:0] left_sum, right_sum;
	logic signed [7:0]  left_pw, right_pw;
	logic               reset_cnt;
	status_t            status;

	// odometry in exact integers
	assign diff    = $signed({item.left_degrees[31], item.left_degrees})
		- $signed({item.right_degrees[31], item.right_degrees});
	assign travel  = $signed({{8{diff[32]}}, diff}) * $signed(41'(ODO_DEG_MUL));
	// target_cm comes from state, not from the sample item
	assign reached = !(travel < $signed({18'd0, 23'(cur.target_cm) * 23'(ODO_CM_MUL)}));

	assign kp  = cur.mode_curve ? cfg.curve_kp    : cfg.straight_kp;
	assign ki  = cur.mode_curve ? cfg.curve_ki    : cfg.straight_ki;
	assign kd  = cur.mode_curve ? cfg.curve_kd    : cfg.straight_kd;
	assign spd = cur.mode_curve ? cfg.curve_speed : cfg.straight_speed;

	assign isum_raw = $signed({{5{cur.integral_sum[7]}}, cur.integral_sum})
		+ $signed({item.line_error[11], item.line_error});
	assign isum     = clamp100(24'(isum_raw));
	assign d_err    = $signed({item.line_error[11], item.line_error})
		- $signed({cur.previous_error[11], cur.previous_error});

	assign p_term = 29'(item.line_error) * 29'($signed({1'b0, kp}));
	assign i_term = 25'(isum) * 25'($signed({1'b0, ki}));
	assign d_term = 30'(d_err) * 30'($signed({1'b0, kd}));

	assign pid_sum   = 32'(p_term) + 32'(i_term) + 32'(d_term);
	// bias negative sums so the shift truncates toward zero
	assign pid_round = pid_sum + (pid_sum[31] ? 32'sd1023 : 32'sd0);
	assign corr      = pid_round[31:GAIN_FRAC];

	assign left_sum  = $signed({17'd0, spd}) + 24'(corr);
	assign right_sum = $signed({17'd0, spd}) - 24'(corr);
	assign left_pw   = clamp100(left_sum);
	assign right_pw  = 8'sd0 - clamp100(right_sum);

	always_comb begin
		nxt       = cur;
		reset_cnt = 1'b0;
		status    = STATUS_IDLE;
		priority if (item.command == CMD_START) begin
			nxt.mode_curve     = item.curve_mode;
			nxt.target_cm      = item.target_distance_cm;
			nxt.integral_sum   = '0;
			nxt.previous_error = '0;
			nxt.run_active     = 1'b1;
			nxt.brake_on       = 1'b0;
			reset_cnt          = 1'b1;
			status             = STATUS_RUN;
		end else if (cur.run_active) begin
			priority if (reached) begin
				nxt.brake_on   = 1'b1;
				nxt.run_active = 1'b0;
				status         = STATUS_REACHED;
			end else if (item.abort_button) begin
				nxt.run_active = 1'b0;
				status         = STATUS_ABORTED;
			end else begin
				nxt.integral_sum     = isum;
				nxt.previous_error   = item.line_error;
				nxt.held_left_power  = left_pw;
				nxt.held_right_power = right_pw;
				nxt.brake_on         = 1'b0;
				status               = STATUS_RUN;
			end
		end else begin
			status = STATUS_IDLE;
		end
	end

	assign result.left_power     = nxt.held_left_power;
	assign result.right_power    = nxt.held_right_power;
	assign result.brake          = nxt.brake_on;
	assign result.reset_counters = reset_cnt;
	assign result.status         = status;

endmodule

`default_nettype wire

@@ rtl/core/line_follow_pid_drive.sv @@
// Line-following PID differential drive controller, top level.
// Depends on lfpd_pkg, lfpd_if, lfpd_cfg_regs and lfpd_step.
`default_nettype none

// One transaction is taken per clock while the result side does not stall, and
// one result comes back per transaction: the request lands in an
// input register, the odometry check and PID update run in one combinational
// pass (three gain multiplies in parallel), and the result is held in an output
// register until the sink takes it. The controller state (integral, last
// error, run flag, held powers) updates on the same edge that loads the
// result register, so a following sample sees it with no bubble. Throughput
// is one transaction per cycle while the result side is ready; a stalled
// result holds and the request side keeps one more transaction in the
// input register. Configuration registers are written over the APB port.
module line_follow_pid_drive import lfpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lfpd_req_if.sink           req,
	lfpd_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_nxt;
	result_t result_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	logic    advance;
	logic    fire;

	lfpd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_in.command            = cmd_t'(req.command);
	assign item_in.curve_mode         = req.curve_mode;
	assign item_in.target_distance_cm = req.target_distance_cm;
	assign item_in.line_error         = req.line_error;
	assign item_in.left_degrees       = req.left_degrees;
	assign item_in.right_degrees      = req.right_degrees;
	assign item_in.abort_button       = req.abort_button;

	// result register free or draining this cycle
	assign advance   = !valid_s2 || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	lfpd_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.cfg    (cfg),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= item_in;
		end
		if (fire) begin
			result_s2 <= result_nxt;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.left_power     = result_s2.left_power;
	assign rsp.right_power    = result_s2.right_power;
	assign rsp.brake          = result_s2.brake;
	assign rsp.reset_counters = result_s2.reset_counters;
	assign rsp.status         = result_s2.status;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the line-following PID drive block.
// Depends on lfpd_pkg, the lfpd_req_if / lfpd_rsp_if channels and line_follow_pid_drive.
`timescale 1ns / 100ps

module tb_top;
	import lfpd_pkg::*;

	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     DRAIN_CYCLES = 8;
	localparam int     LONG_HOLD    = 300;
	localparam longint DEG_MAX      = 64'sd2147483647;
	localparam longint DEG_MIN      = -64'sd2147483648;

	typedef struct {
		item_t   it;
		bit      known;
		result_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	lfpd_req_if req_ch ();
	lfpd_rsp_if rsp_ch ();

	line_follow_pid_drive dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of the registers and controller state
	cfg_t    gains;
	state_t  ctl;
	result_t power_cmd_q[$];

	int fail_count    = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint limit_power(input longint v);
		longint r;
		r = v;
		if (v > 100) r = 100;
		if (v < -100) r = -100;
		return r;
	endfunction

	function automatic result_t drive_step(input item_t it);
		result_t r;
		longint  travel, goal, e, kp, ki, kd, spd, isum, d, corr;
		r = '0;
		r.status = STATUS_IDLE;
		if (it.command == CMD_START) begin
			ctl.mode_curve = it.curve_mode;
			ctl.target_cm = it.target_distance_cm;
			ctl.integral_sum = '0;
			ctl.previous_error = '0;
			ctl.run_active = 1'b1;
			ctl.brake_on = 1'b0;
			r.reset_counters = 1'b1;
			r.status = STATUS_RUN;
		end else if (ctl.run_active) begin
			travel = (longint'($signed(it.left_degrees)) - longint'($signed(it.right_degrees)))
				* 201;
			goal = longint'(ctl.target_cm) * 7200;
			if (!(travel < goal)) begin
				ctl.brake_on = 1'b1;
				ctl.run_active = 1'b0;
				r.status = STATUS_REACHED;
			end else if (it.abort_button) begin
				ctl.run_active = 1'b0;
				r.status = STATUS_ABORTED;
			end else begin
				e = longint'($signed(it.line_error));
				kp = longint'(ctl.mode_curve ? gains.curve_kp : gains.straight_kp);
				ki = longint'(ctl.mode_curve ? gains.curve_ki : gains.straight_ki);
				kd = longint'(ctl.mode_curve ? gains.curve_kd : gains.straight_kd);
				spd = longint'(ctl.mode_curve ? gains.curve_speed : gains.straight_speed);
				isum = limit_power(longint'($signed(ctl.integral_sum)) + e);
				d = e - longint'($signed(ctl.previous_error));
				// signed divide truncates toward zero
				corr = (e * kp + isum * ki + d * kd) / 1024;
				ctl.integral_sum = ISUM_W'(isum);
				ctl.previous_error = ERR_W'(e);
				ctl.held_left_power = POWER_W'(limit_power(spd + corr));
				ctl.held_right_power = POWER_W'(-limit_power(spd - corr));
				ctl.brake_on = 1'b0;
				r.status = STATUS_RUN;
			end
		end
		r.left_power = ctl.held_left_power;
		r.right_power = ctl.held_right_power;
		r.brake = ctl.brake_on;
		return r;
	endfunction

	function automatic dir_row_t row(input cmd_t c, input bit cm, input int tgt, input int err,
			input longint l, input longint rr, input bit ab, input bit known,
			input int lp, input int rp, input bit brk, input bit rc, input status_t st);
		dir_row_t t;
		t.it.command = c;
		t.it.curve_mode = cm;
		t.it.target_distance_cm = TGT_W'(tgt);
		t.it.line_error = ERR_W'(err);
		t.it.left_degrees = DEG_W'(l);
		t.it.right_degrees = DEG_W'(rr);
		t.it.abort_button = ab;
		t.known = known;
		t.res.left_power = POWER_W'(lp);
		t.res.right_power = POWER_W'(rp);
		t.res.brake = brk;
		t.res.reset_counters = rc;
		t.res.status = st;
		return t;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] kept;
		if (idx == REG_STRAIGHT_SPEED || idx == REG_CURVE_SPEED) kept = val & 32'h7F;
		else kept = val & 32'hFFFF;
		case (idx)
			REG_STRAIGHT_KP:    gains.straight_kp = kept[GAIN_W-1:0];
			REG_STRAIGHT_KI:    gains.straight_ki = kept[GAIN_W-1:0];
			REG_STRAIGHT_KD:    gains.straight_kd = kept[GAIN_W-1:0];
			REG_CURVE_KP:       gains.curve_kp = kept[GAIN_W-1:0];
			REG_CURVE_KI:       gains.curve_ki = kept[GAIN_W-1:0];
			REG_CURVE_KD:       gains.curve_kd = kept[GAIN_W-1:0];
			REG_STRAIGHT_SPEED: gains.straight_speed = kept[SPEED_W-1:0];
			REG_CURVE_SPEED:    gains.curve_speed = kept[SPEED_W-1:0];
			default: ;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// read the register back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== kept) begin
			$error("prdata reg %0d: expected %0h, got %0h", idx, kept, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_config(input cfg_t c);
		reg_write(REG_STRAIGHT_KP, 32'(c.straight_kp));
		reg_write(REG_STRAIGHT_KI, 32'(c.straight_ki));
		reg_write(REG_STRAIGHT_KD, 32'(c.straight_kd));
		reg_write(REG_CURVE_KP, 32'(c.curve_kp));
		reg_write(REG_CURVE_KI, 32'(c.curve_ki));
		reg_write(REG_CURVE_KD, 32'(c.curve_kd));
		reg_write(REG_STRAIGHT_SPEED, 32'(c.straight_speed));
		reg_write(REG_CURVE_SPEED, 32'(c.curve_speed));
	endtask

	// offer one transaction; on acceptance record the expected result (typed for known rows, else predicted)
	task automatic send_item(input item_t it, input bit known, input result_t typed);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= it.command;
		req_ch.curve_mode <= it.curve_mode;
		req_ch.target_distance_cm <= it.target_distance_cm;
		req_ch.line_error <= it.line_error;
		req_ch.left_degrees <= it.left_degrees;
		req_ch.right_degrees <= it.right_degrees;
		req_ch.abort_button <= it.abort_button;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = drive_step(it);
		power_cmd_q.push_back(known ? typed : predicted);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (power_cmd_q.size() != 0) @(posedge clk);
	endtask

	task automatic wait_drained();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_result();
		result_t want;
		results_seen++;
		if (power_cmd_q.size() == 0) begin
			$error("result transaction with nothing pending");
			fail_count++;
		end else begin
			want = power_cmd_q.pop_front();
			if (rsp_ch.left_power !== want.left_power) begin
				$error("left_power: expected %0d, got %0d", want.left_power, rsp_ch.left_power);
				fail_count++;
			end
			if (rsp_ch.right_power !== want.right_power) begin
				$error("right_power: expected %0d, got %0d", want.right_power,
					rsp_ch.right_power);
				fail_count++;
			end
			if (rsp_ch.brake !== want.brake) begin
				$error("brake: expected %0d, got %0d", want.brake, rsp_ch.brake);
				fail_count++;
			end
			if (rsp_ch.reset_counters !== want.reset_counters) begin
				$error("reset_counters: expected %0d, got %0d", want.reset_counters,
					rsp_ch.reset_counters);
				fail_count++;
			end
			if (rsp_ch.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
				fail_count++;
			end
		end
	endtask

	// result side: random stalls plus one long hold-off that backs up the input
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) check_result();
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		dir_row_t dir_rows[$];
		cfg_t     cfg;
		item_t    it;
		int       seg, n, pick;
		int       seg_items[4];
		longint   goal_deg, diff, base;

		seg_items = '{200, 100, 100, 200};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_START;
		req_ch.curve_mode <= 1'b0;
		req_ch.target_distance_cm <= '0;
		req_ch.line_error <= '0;
		req_ch.left_degrees <= '0;
		req_ch.right_degrees <= '0;
		req_ch.abort_button <= 1'b0;

		gains = '{RST_STRAIGHT_KP, RST_STRAIGHT_KI, RST_STRAIGHT_KD, RST_CURVE_KP,
			RST_CURVE_KI, RST_CURVE_KD, RST_STRAIGHT_SPEED, RST_CURVE_SPEED};
		ctl = '0;

		// cmd, curve, target, error, left, right, abort | typed, left, right, brake, rst, status
		dir_rows.push_back(row(CMD_SAMPLE, 1, 1023, 2047, 5, -5, 1,
			1, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, STATUS_RUN));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, -2048, 0, 0, 0,
			1, 0, 0, 1, 0, STATUS_REACHED));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 0, DEG_MAX, DEG_MIN, 1,
			1, 0, 0, 1, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 1, 1023, 0, 0, 0, 0, 1, 0, 0, 0, 1, STATUS_RUN));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 2047, 100, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, -2048, DEG_MIN, DEG_MAX, 0,
			0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 5, 10, 0, 1, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 5, 10, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 0, 67, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		// one degree short of the exact target, then exactly on it with abort pressed
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, -7, 2399, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 300, 1200, -1199, 0,
			0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 300, 1200, -1200, 1,
			0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, -1, DEG_MAX, DEG_MIN, 0,
			0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 1, 500, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_START, 1, 500, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, -1, -50, 50, 0, 0, 0, 0, 0, 0, STATUS_IDLE));
		dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 0, 3, 0, 1, 0, 0, 0, 0, 0, STATUS_IDLE));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 62;
		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);

		for (seg = 0; seg < 4; seg++) begin
			wait_drained();
			case (seg)
				0: begin
					cfg.straight_kp = GAIN_W'($urandom_range(16383));
					cfg.straight_ki = GAIN_W'($urandom_range(2047));
					cfg.straight_kd = GAIN_W'($urandom_range(16383));
					cfg.curve_kp = GAIN_W'($urandom_range(16383));
					cfg.curve_ki = GAIN_W'($urandom_range(2047));
					cfg.curve_kd = GAIN_W'($urandom_range(16383));
					cfg.straight_speed = SPEED_W'($urandom_range(100));
					cfg.curve_speed = SPEED_W'($urandom_range(100));
				end
				1: cfg = '1;
				2: cfg = '0;
				default: begin
					cfg.straight_kp = GAIN_W'($urandom);
					cfg.straight_ki = GAIN_W'($urandom);
					cfg.straight_kd = GAIN_W'($urandom);
					cfg.curve_kp = GAIN_W'($urandom_range(8191));
					cfg.curve_ki = GAIN_W'($urandom_range(1023));
					cfg.curve_kd = GAIN_W'($urandom_range(8191));
					cfg.straight_speed = SPEED_W'($urandom_range(127));
					cfg.curve_speed = SPEED_W'($urandom_range(100));
				end
			endcase
			load_config(cfg);
			@(posedge clk);
			send_idle_pct = (seg == 0) ? 22 : (seg < 3) ? 62 : 0;
			recv_idle_pct = (seg == 0) ? 62 : (seg < 3) ? 22 : 0;

			n = 0;
			while (n < seg_items[seg]) begin
				if (seg == 0 && n == 100) hold_until_drained();
				it.command = CMD_SAMPLE;
				it.curve_mode = 1'($urandom_range(1));
				it.target_distance_cm = TGT_W'($urandom);
				if ($urandom_range(9) < 7) it.line_error = ERR_W'(int'($urandom_range(400)) - 200);
				else it.line_error = ERR_W'($urandom);
				it.left_degrees = DEG_W'($urandom);
				it.right_degrees = DEG_W'($urandom);
				it.abort_button = 1'b0;
				pick = $urandom_range(99);
				if (!ctl.run_active) begin
					if (pick < 85) begin
						it.command = CMD_START;
						pick = $urandom_range(99);
						if (pick < 70) it.target_distance_cm = TGT_W'($urandom_range(1, 40));
						else if (pick < 80) it.target_distance_cm = '0;
					end else begin
						it.command = cmd_t'($urandom_range(1));
						it.abort_button = 1'($urandom_range(1));
					end
				end else begin
					// smallest wheel difference that counts as arrived
					goal_deg = (longint'(ctl.target_cm) * 7200 + 200) / 201;
					base = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sd1073741824;
					if (pick < 4) begin
						it.abort_button = 1'($urandom_range(1));
					end else if (pick < 20 && pick >= 17) begin
						it.command = CMD_START;
						it.target_distance_cm = TGT_W'($urandom_range(60));
					end else begin
						if (pick < 17 && pick >= 9) diff = goal_deg + $urandom_range(3);
						else diff = goal_deg - 1
							- longint'($urandom_range(32'(goal_deg + 50)));
						it.abort_button = (pick < 9);
						it.left_degrees = DEG_W'(base);
						it.right_degrees = DEG_W'(base - diff);
					end
				end
				// samples that land while idle change nothing; keep them out of the count
				if (it.command == CMD_START || ctl.run_active) n++;
				send_item(it, 1'b0, '0);
			end
		end

		wait_drained();
		if (fail_count == 0 && power_cmd_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
